// ----- rtl/core/clkd_pkg.sv -----
`timescale 1ns / 1ps

package clkd_pkg;

  // Prescaler and blink timing
  localparam int unsigned TICKS_PER_SECOND = 128;
  localparam int unsigned BLINK_TICKS      = 32;

  localparam int unsigned TICK_W  = $clog2(TICKS_PER_SECOND);
  localparam int unsigned BLINK_W = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;

  // Field widths
  localparam int unsigned MASK_W = 8;
  localparam int unsigned ENC_W  = 2;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;

  // Wrap limits
  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);
  localparam logic [HOUR_W-1:0] HALF_DAY  = HOUR_W'(12);

  // Preset time 11:44:55
  localparam logic [HOUR_W-1:0] PRESET_HOUR = HOUR_W'(11);
  localparam logic [MIN_W-1:0]  PRESET_MIN  = MIN_W'(44);
  localparam logic [SEC_W-1:0]  PRESET_SEC  = SEC_W'(55);

  // Button codes (exact mask match)
  localparam logic [MASK_W-1:0] BTN_PRESET  = 8'h10;
  localparam logic [MASK_W-1:0] BTN_FMT24   = 8'h20;
  localparam logic [MASK_W-1:0] BTN_SET_MIN = 8'h40;
  localparam logic [MASK_W-1:0] BTN_SET_HR  = 8'h80;

  // Encoder detent codes
  localparam logic [ENC_W-1:0] ENC_PREV_UP = 2'd1;
  localparam logic [ENC_W-1:0] ENC_PREV_DN = 2'd2;
  localparam logic [ENC_W-1:0] ENC_DETENT  = 2'd3;

  // Clock state after one tick, handed to the display formatter
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              blink;
    logic              mode_24h;
    logic              set_min;
    logic              set_hr;
  } view_t;

  // One display result
  typedef struct packed {
    logic [1:0]       hour_tens;
    logic [3:0]       hour_ones;
    logic [2:0]       minute_tens;
    logic [3:0]       minute_ones;
    logic             leading_blank;
    logic             hours_blank;
    logic             minutes_blank;
    logic             colon_on;
    logic             pm_dot;
    logic             format24_dot;
    logic [SEC_W-1:0] seconds_now;
  } res_t;

endpackage

// ----- rtl/core/clkd_in_if.sv -----
`timescale 1ns / 1ps

interface clkd_in_if
  import clkd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] button_mask;
  logic [ENC_W-1:0]  encoder_phase;

  modport source (output valid, output button_mask, output encoder_phase, input ready);
  modport sink   (input valid, input button_mask, input encoder_phase, output ready);
endinterface

// ----- rtl/core/clkd_out_if.sv -----
`timescale 1ns / 1ps

interface clkd_out_if
  import clkd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       hour_tens;
  logic [3:0]       hour_ones;
  logic [2:0]       minute_tens;
  logic [3:0]       minute_ones;
  logic             leading_blank;
  logic             hours_blank;
  logic             minutes_blank;
  logic             colon_on;
  logic             pm_dot;
  logic             format24_dot;
  logic [SEC_W-1:0] seconds_now;

  modport source (
    output valid, output hour_tens, output hour_ones, output minute_tens,
    output minute_ones, output leading_blank, output hours_blank,
    output minutes_blank, output colon_on, output pm_dot, output format24_dot,
    output seconds_now, input ready
  );
  modport sink (
    input valid, input hour_tens, input hour_ones, input minute_tens,
    input minute_ones, input leading_blank, input hours_blank,
    input minutes_blank, input colon_on, input pm_dot, input format24_dot,
    input seconds_now, output ready
  );
endinterface

// ----- rtl/core/clkd_time.sv -----
`timescale 1ns / 1ps

module clkd_time
  import clkd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic [ENC_W-1:0]  phase_i,
  output view_t             view_o
);

  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [BLINK_W-1:0] bcnt_q, bcnt_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [MIN_W-1:0]   min_q, min_d;
  logic [HOUR_W-1:0]  hour_q, hour_d;
  logic               blink_q, blink_d;
  logic               mode_q, mode_d;
  logic               setm_q, setm_d;
  logic               seth_q, seth_d;
  logic               rel_q, rel_d;
  logic [MASK_W-1:0]  last_q, last_d;
  logic [ENC_W-1:0]   enc_q, enc_d;

  logic [TICK_W:0]    tick_inc;
  logic [BLINK_W:0]   bcnt_inc;
  logic [BLINK_W-1:0] bcnt_wrap;
  logic               sec_tick;
  logic               act;
  logic               up;
  logic               dn;

  always_comb begin
    tick_inc  = {1'b0, tick_q} + 1'b1;
    sec_tick  = (tick_inc == (TICK_W+1)'(TICKS_PER_SECOND));
    // bcnt tracks the tick count modulo the blink period
    bcnt_inc  = {1'b0, bcnt_q} + 1'b1;
    bcnt_wrap = (bcnt_inc == (BLINK_W+1)'(BLINK_TICKS)) ? '0 : bcnt_inc[BLINK_W-1:0];

    tick_d  = sec_tick ? '0 : tick_inc[TICK_W-1:0];
    bcnt_d  = sec_tick ? '0 : bcnt_wrap;
    blink_d = blink_q ^ (bcnt_wrap == '0);
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    mode_d  = mode_q;
    setm_d  = setm_q;
    seth_d  = seth_q;
    rel_d   = rel_q;
    last_d  = last_q;
    enc_d   = phase_i;

    // prescaler carry
    if (sec_tick) begin
      if (sec_q == SEC_LAST) begin
        sec_d = '0;
        if (min_q == MIN_LAST) begin
          min_d  = '0;
          hour_d = (hour_q == HOUR_LAST) ? '0 : hour_q + 1'b1;
        end else begin
          min_d = min_q + 1'b1;
        end
      end else begin
        sec_d = sec_q + 1'b1;
      end
    end

    // buttons: act on first press or on any change of the pressed set
    act = (mask_i != '0) && (rel_q || (mask_i != last_q));
    if (mask_i != '0) begin
      rel_d  = 1'b0;
      last_d = mask_i;
    end else begin
      rel_d = 1'b1;
    end
    if (act) begin
      case (mask_i)
        BTN_PRESET: begin
          hour_d = PRESET_HOUR;
          min_d  = PRESET_MIN;
          sec_d  = PRESET_SEC;
        end
        BTN_FMT24:   mode_d = ~mode_q;
        BTN_SET_MIN: begin
          setm_d = ~setm_q;
          seth_d = 1'b0;
        end
        BTN_SET_HR: begin
          seth_d = ~seth_q;
          setm_d = 1'b0;
        end
        default: ;
      endcase
    end

    // encoder detents
    up = (enc_q == ENC_PREV_UP) && (phase_i == ENC_DETENT);
    dn = (enc_q == ENC_PREV_DN) && (phase_i == ENC_DETENT);
    if (up || dn) begin
      if (setm_d) begin
        sec_d = '0;
        if (up) min_d = (min_d == MIN_LAST) ? '0 : min_d + 1'b1;
        else    min_d = (min_d == '0) ? MIN_LAST : min_d - 1'b1;
      end
      if (seth_d) begin
        sec_d = '0;
        if (up) hour_d = (hour_d == HOUR_LAST) ? '0 : hour_d + 1'b1;
        else    hour_d = (hour_d == '0) ? HOUR_LAST : hour_d - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      bcnt_q  <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      blink_q <= 1'b0;
      mode_q  <= 1'b0;
      setm_q  <= 1'b0;
      seth_q  <= 1'b0;
      rel_q   <= 1'b1;
      last_q  <= '0;
      enc_q   <= '0;
    end else if (step_i) begin
      tick_q  <= tick_d;
      bcnt_q  <= bcnt_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      blink_q <= blink_d;
      mode_q  <= mode_d;
      setm_q  <= setm_d;
      seth_q  <= seth_d;
      rel_q   <= rel_d;
      last_q  <= last_d;
      enc_q   <= enc_d;
    end
  end

  assign view_o = '{hour: hour_d, minute: min_d, second: sec_d, blink: blink_d,
                    mode_24h: mode_d, set_min: setm_d, set_hr: seth_d};

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(setm_q && seth_q))
    else $error("both set modes on");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (hour_q <= HOUR_LAST) && (min_q <= MIN_LAST) && (sec_q <= SEC_LAST))
    else $error("time count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !step_i |=> $stable(tick_q))
    else $error("prescaler moved without a beat");

endmodule

// ----- rtl/core/clkd_disp.sv -----
`timescale 1ns / 1ps

module clkd_disp
  import clkd_pkg::*;
(
  input  view_t view_i,
  output res_t  res_o
);

  logic [HOUR_W-1:0] h12;
  logic [HOUR_W-1:0] shown;
  logic [HOUR_W-1:0] h_ones;
  logic [1:0]        h_tens;
  logic [2:0]        m_tens;
  logic [MIN_W-1:0]  m_ones;

  always_comb begin
    h12 = (view_i.hour >= HALF_DAY) ? view_i.hour - HALF_DAY : view_i.hour;
    if (view_i.mode_24h)  shown = view_i.hour;
    else if (h12 == '0)   shown = HALF_DAY;
    else                  shown = h12;

    // hour below 24: tens by compare
    if (shown >= HOUR_W'(20)) begin
      h_tens = 2'd2;
      h_ones = shown - HOUR_W'(20);
    end else if (shown >= HOUR_W'(10)) begin
      h_tens = 2'd1;
      h_ones = shown - HOUR_W'(10);
    end else begin
      h_tens = 2'd0;
      h_ones = shown;
    end

    // minute below 60: tens by compare chain
    if      (view_i.minute >= MIN_W'(50)) m_tens = 3'd5;
    else if (view_i.minute >= MIN_W'(40)) m_tens = 3'd4;
    else if (view_i.minute >= MIN_W'(30)) m_tens = 3'd3;
    else if (view_i.minute >= MIN_W'(20)) m_tens = 3'd2;
    else if (view_i.minute >= MIN_W'(10)) m_tens = 3'd1;
    else                                  m_tens = 3'd0;
    m_ones = view_i.minute - MIN_W'({m_tens, 3'b000} + {2'b00, m_tens, 1'b0});

    res_o.hour_tens     = h_tens;
    res_o.hour_ones     = h_ones[3:0];
    res_o.minute_tens   = m_tens;
    res_o.minute_ones   = m_ones[3:0];
    res_o.leading_blank = !view_i.mode_24h && (shown < HOUR_W'(10));
    res_o.hours_blank   = view_i.set_hr && view_i.blink;
    res_o.minutes_blank = view_i.set_min && view_i.blink;
    res_o.colon_on      = !view_i.second[0];
    res_o.pm_dot        = (view_i.hour >= HALF_DAY) && !view_i.mode_24h;
    res_o.format24_dot  = view_i.mode_24h;
    res_o.seconds_now   = view_i.second;
  end

endmodule

// ----- rtl/core/clock_with_set_mode_and_display_core.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Beat payload                                  Handshake
// in_i     in   button_mask[7:0], encoder_phase[1:0]          valid/ready
// out_o    out  hour/minute digits, blank flags, colon, dots,  valid/ready
//               seconds_now[5:0]
//
// One tick beat per cycle sustained while out_o takes each result. A beat
// lands in the input register; as it advances, the clock state steps, the
// display word is registered and out_o valid rises. The input register
// stalls only while it is full and out_o holds an untaken result; ready
// never waits on idle.
// Async active-low reset clears time to 00:00:00, 12-hour mode, no set mode.

module clock_with_set_mode_and_display_core
  import clkd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  clkd_in_if.sink    in_i,
  clkd_out_if.source out_o
);

  // input register
  logic              in_vld_q;
  logic [MASK_W-1:0] mask_q;
  logic [ENC_W-1:0]  phase_q;

  // result register
  logic              out_vld_q;
  res_t              res_q;

  logic  advance;   // input-register beat moves into the clock state
  view_t view;
  res_t  res;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mask_q  <= in_i.button_mask;
      phase_q <= in_i.encoder_phase;
    end
  end

  clkd_time u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .mask_i  (mask_q),
    .phase_i (phase_q),
    .view_o  (view)
  );

  clkd_disp u_disp (
    .view_i (view),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.hour_tens     = res_q.hour_tens;
  assign out_o.hour_ones     = res_q.hour_ones;
  assign out_o.minute_tens   = res_q.minute_tens;
  assign out_o.minute_ones   = res_q.minute_ones;
  assign out_o.leading_blank = res_q.leading_blank;
  assign out_o.hours_blank   = res_q.hours_blank;
  assign out_o.minutes_blank = res_q.minutes_blank;
  assign out_o.colon_on      = res_q.colon_on;
  assign out_o.pm_dot        = res_q.pm_dot;
  assign out_o.format24_dot  = res_q.format24_dot;
  assign out_o.seconds_now   = res_q.seconds_now;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_vld_q |-> in_i.ready)
    else $error("input stalled with empty result register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q |-> !(res_q.hours_blank && res_q.minutes_blank))
    else $error("both digit pairs blinking");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q && res_q.format24_dot |-> !res_q.pm_dot && !res_q.leading_blank)
    else $error("12-hour flags shown in 24-hour mode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   advance |=> out_vld_q)
    else $error("stepped beat lost its result");

endmodule
